// ----- src/mnnt_pkg.sv -----
// ----------------------------------------------------------------------------
// mnnt_pkg
// shared constants, state encoding and controller/datapath bundles for the
// mutual nearest neighbour tree builder
// ----------------------------------------------------------------------------
package mnnt_pkg;

   localparam int COORD_W       = 24;
   localparam int IDX_W         = 6;
   localparam int CNT_W         = 6;
   localparam int DIST_W        = 2 * (COORD_W + 1) + 2;
   localparam int MAX_STARS_DEF = 32;
   localparam int DIMS_DEF      = 3;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_ROUND,
      ST_NA_SCAN,
      ST_NA_LOAD,
      ST_NA_SWEEP,
      ST_PAIR_SCAN,
      ST_PAIR_NA,
      ST_PAIR_NB,
      ST_PAIR_RA,
      ST_PAIR_RB,
      ST_SINGLE_OUT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             pos_rd_en;
      logic [IDX_W-1:0] pos_rd_addr;
      logic             pos_wr_load;
      logic             pos_wr_merge;
      logic [IDX_W-1:0] pos_wr_addr;
      logic             nb_rd_en;
      logic [IDX_W-1:0] nb_rd_addr;
      logic             nb_wr_en;
      logic [IDX_W-1:0] nb_wr_addr;
      logic             pa_load;
      logic             best_clear;
      logic             sweep_issue;
      logic [IDX_W-1:0] cur_a;
      logic [IDX_W-1:0] cur_b;
      logic             emit_merge;
      logic             emit_single;
      logic             attach;
      logic             attach_clear;
      logic [CNT_W-1:0] star_total;
      logic             overflow;
   } cmd_type;

   typedef struct packed {
      logic             free_a;
      logic [IDX_W-1:0] nb_rd_data;
      logic             sweep_busy;
      logic             out_free;
   } status_type;

endpackage

// ----- src/mnnt_if.sv -----
// ----------------------------------------------------------------------------
// mnnt_req_if / mnnt_rsp_if
// valid/ready channels for star requests and tree node records
// ----------------------------------------------------------------------------
interface mnnt_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mnnt_pkg::COORD_W-1:0] coord_x;
   logic signed [mnnt_pkg::COORD_W-1:0] coord_y;
   logic signed [mnnt_pkg::COORD_W-1:0] coord_z;
   logic                                last_star;
   modport source (output valid, coord_x, coord_y, coord_z, last_star, input ready);
   modport sink   (input valid, coord_x, coord_y, coord_z, last_star, output ready);
endinterface

interface mnnt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mnnt_pkg::IDX_W-1:0]          node_id;
   logic [mnnt_pkg::IDX_W-1:0]          child_first;
   logic [mnnt_pkg::IDX_W-1:0]          child_second;
   logic signed [mnnt_pkg::COORD_W-1:0] mid_x;
   logic signed [mnnt_pkg::COORD_W-1:0] mid_y;
   logic signed [mnnt_pkg::COORD_W-1:0] mid_z;
   logic [mnnt_pkg::CNT_W-1:0]          member_count;
   logic                                last_node;
   logic                                empty_tree;
   logic                                overflow;
   modport source (output valid, node_id, child_first, child_second, mid_x, mid_y, mid_z,
                   member_count, last_node, empty_tree, overflow, input ready);
   modport sink   (input valid, node_id, child_first, child_second, mid_x, mid_y, mid_z,
                   member_count, last_node, empty_tree, overflow, output ready);
endinterface

// ----- src/mutual_nearest_neighbour_tree_top.sv -----
// ----------------------------------------------------------------------------
// mutual_nearest_neighbour_tree_top
// loads star positions, then builds a binary tree by merging mutually
// nearest free nodes round by round, one record per new node
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    coord_x, coord_y, coord_z, last_star
//  rsp_chan  out  valid/ready    node_id, children, mid_x/y/z, counts, flags
//
// stars load one per cycle while the block is loading
// after the last star each round runs, per free node, a nearest search
// that sweeps every node of the round and then the pairing states; the
// single read port of the position ram sets this pace
// synchronous reset clears all control state; no clearing pass is needed
// a stalled result holds the merge until the output register frees
// ----------------------------------------------------------------------------
module mutual_nearest_neighbour_tree_top #(
   parameter int MAX_STARS  = mnnt_pkg::MAX_STARS_DEF,
   parameter int DIMENSIONS = mnnt_pkg::DIMS_DEF
) (
   input logic        clock,
   input logic        reset,
   mnnt_req_if.sink   req_chan,
   mnnt_rsp_if.source rsp_chan
);

   mnnt_pkg::cmd_type    cmd;
   mnnt_pkg::status_type status;
   logic                 req_ready;

   assign req_chan.ready = req_ready;

   mnnt_ctrl #(.MAX_STARS(MAX_STARS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_star),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mnnt_dp #(.MAX_STARS(MAX_STARS), .DIMENSIONS(DIMENSIONS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- src/mnnt_ram.sv -----
// ----------------------------------------------------------------------------
// mnnt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mnnt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mnnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mnnt_ctrl
// sequencer for star loading, nearest neighbour rounds and pair merging
// ----------------------------------------------------------------------------
module mnnt_ctrl #(
   parameter int MAX_STARS = mnnt_pkg::MAX_STARS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  mnnt_pkg::status_type status,
   output mnnt_pkg::cmd_type    cmd
);

   localparam int NODE_CAP = 2 * MAX_STARS - 1;
   localparam int AW       = $clog2(NODE_CAP);
   localparam int CW       = $clog2(NODE_CAP + 1);
   localparam int RW       = $clog2(MAX_STARS + 1);

   mnnt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] star_total_ff, star_total_in;
   logic [CW-1:0] node_total_ff, node_total_in;
   logic [CW-1:0] free_cnt_ff, free_cnt_in;
   logic [CW-1:0] round_total_ff, round_total_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;
   logic [RW-1:0] round_ff, round_in;
   logic          overflow_ff, overflow_in;
   logic [CW-1:0] nb;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mnnt_pkg::ST_LOAD;
         star_total_ff  <= '0;
         node_total_ff  <= '0;
         free_cnt_ff    <= '0;
         round_total_ff <= '0;
         a_ff           <= '0;
         b_ff           <= '0;
         round_ff       <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         star_total_ff  <= star_total_in;
         node_total_ff  <= node_total_in;
         free_cnt_ff    <= free_cnt_in;
         round_total_ff <= round_total_in;
         a_ff           <= a_in;
         b_ff           <= b_in;
         round_ff       <= round_in;
         overflow_ff    <= overflow_in;
      end
   end

   assign nb = CW'(status.nb_rd_data[AW-1:0]);

   always_comb begin
      state_in       = state_ff;
      star_total_in  = star_total_ff;
      node_total_in  = node_total_ff;
      free_cnt_in    = free_cnt_ff;
      round_total_in = round_total_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      round_in       = round_ff;
      overflow_in    = overflow_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.cur_a      = mnnt_pkg::IDX_W'(a_ff);
      cmd.cur_b      = mnnt_pkg::IDX_W'(b_ff);
      cmd.star_total = mnnt_pkg::CNT_W'(star_total_ff);
      cmd.overflow   = overflow_ff;

      unique case (state_ff)
         mnnt_pkg::ST_LOAD: begin
            req_ready       = 1'b1;
            cmd.pos_wr_addr = mnnt_pkg::IDX_W'(star_total_ff);
            if (req_valid) begin
               if (star_total_ff < CW'(MAX_STARS)) begin
                  cmd.pos_wr_load = 1'b1;
                  star_total_in   = star_total_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_last) begin
                  state_in = mnnt_pkg::ST_START;
               end
            end
         end
         mnnt_pkg::ST_START: begin
            node_total_in = star_total_ff;
            free_cnt_in   = star_total_ff;
            round_in      = '0;
            if (star_total_ff == CW'(1)) begin
               cmd.pos_rd_en   = 1'b1;
               cmd.pos_rd_addr = '0;
               state_in        = mnnt_pkg::ST_SINGLE_OUT;
            end else begin
               state_in = mnnt_pkg::ST_ROUND;
            end
         end
         mnnt_pkg::ST_ROUND: begin
            if (round_ff == RW'(MAX_STARS) || node_total_ff == CW'(NODE_CAP) ||
                free_cnt_ff <= CW'(1)) begin
               state_in = mnnt_pkg::ST_FINISH;
            end else begin
               round_total_in = node_total_ff;
               a_in           = '0;
               state_in       = mnnt_pkg::ST_NA_SCAN;
            end
         end
         mnnt_pkg::ST_NA_SCAN: begin
            if (a_ff == round_total_ff) begin
               a_in     = '0;
               state_in = mnnt_pkg::ST_PAIR_SCAN;
            end else if (!status.free_a) begin
               a_in = a_ff + 1'b1;
            end else begin
               cmd.pos_rd_en   = 1'b1;
               cmd.pos_rd_addr = mnnt_pkg::IDX_W'(a_ff);
               state_in        = mnnt_pkg::ST_NA_LOAD;
            end
         end
         mnnt_pkg::ST_NA_LOAD: begin
            cmd.pa_load    = 1'b1;
            cmd.best_clear = 1'b1;
            b_in           = '0;
            state_in       = mnnt_pkg::ST_NA_SWEEP;
         end
         mnnt_pkg::ST_NA_SWEEP: begin
            if (b_ff < round_total_ff) begin
               cmd.sweep_issue = 1'b1;
               cmd.pos_rd_en   = 1'b1;
               cmd.pos_rd_addr = mnnt_pkg::IDX_W'(b_ff);
               b_in            = b_ff + 1'b1;
            end else if (!status.sweep_busy) begin
               cmd.nb_wr_en   = 1'b1;
               cmd.nb_wr_addr = mnnt_pkg::IDX_W'(a_ff);
               a_in           = a_ff + 1'b1;
               state_in       = mnnt_pkg::ST_NA_SCAN;
            end
         end
         mnnt_pkg::ST_PAIR_SCAN: begin
            if (a_ff == round_total_ff) begin
               round_in = round_ff + 1'b1;
               state_in = mnnt_pkg::ST_ROUND;
            end else if (!status.free_a) begin
               a_in = a_ff + 1'b1;
            end else begin
               cmd.nb_rd_en   = 1'b1;
               cmd.nb_rd_addr = mnnt_pkg::IDX_W'(a_ff);
               state_in       = mnnt_pkg::ST_PAIR_NA;
            end
         end
         mnnt_pkg::ST_PAIR_NA: begin
            b_in = nb;
            if (nb > a_ff) begin
               cmd.nb_rd_en   = 1'b1;
               cmd.nb_rd_addr = mnnt_pkg::IDX_W'(nb);
               state_in       = mnnt_pkg::ST_PAIR_NB;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = mnnt_pkg::ST_PAIR_SCAN;
            end
         end
         mnnt_pkg::ST_PAIR_NB: begin
            if (nb == a_ff && node_total_ff < CW'(NODE_CAP)) begin
               cmd.pos_rd_en   = 1'b1;
               cmd.pos_rd_addr = mnnt_pkg::IDX_W'(a_ff);
               state_in        = mnnt_pkg::ST_PAIR_RA;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = mnnt_pkg::ST_PAIR_SCAN;
            end
         end
         mnnt_pkg::ST_PAIR_RA: begin
            cmd.pa_load     = 1'b1;
            cmd.pos_rd_en   = 1'b1;
            cmd.pos_rd_addr = mnnt_pkg::IDX_W'(b_ff);
            state_in        = mnnt_pkg::ST_PAIR_RB;
         end
         mnnt_pkg::ST_PAIR_RB: begin
            cmd.pos_wr_addr = mnnt_pkg::IDX_W'(node_total_ff);
            if (status.out_free) begin
               cmd.pos_wr_merge = 1'b1;
               cmd.emit_merge   = 1'b1;
               cmd.attach       = 1'b1;
               node_total_in    = node_total_ff + 1'b1;
               free_cnt_in      = free_cnt_ff - 1'b1;
               a_in             = a_ff + 1'b1;
               state_in         = mnnt_pkg::ST_PAIR_SCAN;
            end
         end
         mnnt_pkg::ST_SINGLE_OUT: begin
            if (status.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = mnnt_pkg::ST_FINISH;
            end
         end
         mnnt_pkg::ST_FINISH: begin
            cmd.attach_clear = 1'b1;
            star_total_in    = '0;
            node_total_in    = '0;
            overflow_in      = 1'b0;
            state_in         = mnnt_pkg::ST_LOAD;
         end
         default: begin
            state_in = mnnt_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// ----- src/mnnt_dp.sv -----
// ----------------------------------------------------------------------------
// mnnt_dp
// node storage, squared distance pipeline, nearest tracking, midpoint merge
// and the record output register
// ----------------------------------------------------------------------------
module mnnt_dp #(
   parameter int MAX_STARS  = mnnt_pkg::MAX_STARS_DEF,
   parameter int DIMENSIONS = mnnt_pkg::DIMS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mnnt_pkg::cmd_type    cmd,
   output mnnt_pkg::status_type status,
   mnnt_req_if.sink             req_chan,
   mnnt_rsp_if.source           rsp_chan
);

   localparam int C        = mnnt_pkg::COORD_W;
   localparam int NODE_CAP = 2 * MAX_STARS - 1;
   localparam int AW       = $clog2(NODE_CAP);
   localparam int MW       = $clog2(MAX_STARS + 1);
   localparam int PW       = 3 * C + MW;
   localparam int SQ_W     = 2 * (C + 1);
   localparam int DW       = mnnt_pkg::DIST_W;

   logic [PW-1:0] pos_wr_data, pos_rd_data, load_word, merge_word;
   logic [AW-1:0] nb_rd_data;
   logic [PW-1:0] pa_ff;
   logic [(1 << AW)-1:0] attached_ff;

   logic          s1_act_ff, s1_v_ff, s2_act_ff, s2_v_ff, s3_act_ff, s3_v_ff;
   logic [AW-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [SQ_W-1:0] sq_ff [3];
   logic [SQ_W-1:0] sq_in [3];
   logic [DW-1:0] s3_sum_ff;
   logic [DW-1:0] best_ff;
   logic [AW-1:0] best_idx_ff;
   logic          best_have_ff;
   logic [C:0]    mid_sum [3];
   logic [MW-1:0] merge_members;

   logic                  rsp_valid_ff;
   logic [mnnt_pkg::IDX_W-1:0] node_id_ff, child_first_ff, child_second_ff;
   logic [C-1:0]          mid_x_ff, mid_y_ff, mid_z_ff;
   logic [mnnt_pkg::CNT_W-1:0] members_ff;
   logic                  last_node_ff, empty_ff, ovf_ff;

   // storage word: members, z, y, x
   assign load_word = {MW'(1),
                       (DIMENSIONS > 2) ? req_chan.coord_z : {C{1'b0}},
                       (DIMENSIONS > 1) ? req_chan.coord_y : {C{1'b0}},
                       req_chan.coord_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mid_sum[k] = {pa_ff[k*C + C-1], pa_ff[k*C +: C]}
                    + {pos_rd_data[k*C + C-1], pos_rd_data[k*C +: C]};
      end
   end

   assign merge_members = pa_ff[3*C +: MW] + pos_rd_data[3*C +: MW];
   assign merge_word    = {merge_members, mid_sum[2][C:1], mid_sum[1][C:1], mid_sum[0][C:1]};
   assign pos_wr_data   = cmd.pos_wr_load ? load_word : merge_word;

   mnnt_ram #(.WIDTH(PW), .DEPTH(NODE_CAP)) u_pos_ram (
      .clock   (clock),
      .wr_en   (cmd.pos_wr_load | cmd.pos_wr_merge),
      .wr_addr (cmd.pos_wr_addr[AW-1:0]),
      .wr_data (pos_wr_data),
      .rd_en   (cmd.pos_rd_en),
      .rd_addr (cmd.pos_rd_addr[AW-1:0]),
      .rd_data (pos_rd_data)
   );

   mnnt_ram #(.WIDTH(AW), .DEPTH(NODE_CAP)) u_nb_ram (
      .clock   (clock),
      .wr_en   (cmd.nb_wr_en),
      .wr_addr (cmd.nb_wr_addr[AW-1:0]),
      .wr_data (best_idx_ff),
      .rd_en   (cmd.nb_rd_en),
      .rd_addr (cmd.nb_rd_addr[AW-1:0]),
      .rd_data (nb_rd_data)
   );

   // squared distance per axis
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [C:0] d;
         logic signed [SQ_W-1:0] p;
         d = $signed({pa_ff[k*C + C-1], pa_ff[k*C +: C]})
           - $signed({pos_rd_data[k*C + C-1], pos_rd_data[k*C +: C]});
         p = d * d;
         sq_in[k] = p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_act_ff    <= 1'b0;
         s2_act_ff    <= 1'b0;
         s3_act_ff    <= 1'b0;
         best_have_ff <= 1'b0;
         attached_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_act_ff <= cmd.sweep_issue;
         s2_act_ff <= s1_act_ff;
         s3_act_ff <= s2_act_ff;
         if (cmd.best_clear) begin
            best_have_ff <= 1'b0;
         end else if (s3_act_ff && s3_v_ff &&
                      (!best_have_ff || s3_sum_ff < best_ff)) begin
            best_have_ff <= 1'b1;
         end
         if (cmd.attach_clear) begin
            attached_ff <= '0;
         end else if (cmd.attach) begin
            attached_ff[cmd.cur_a[AW-1:0]] <= 1'b1;
            attached_ff[cmd.cur_b[AW-1:0]] <= 1'b1;
         end
         if (cmd.emit_merge || cmd.emit_single) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pa_load) begin
         pa_ff <= pos_rd_data;
      end
      s1_v_ff   <= cmd.sweep_issue && !attached_ff[cmd.cur_b[AW-1:0]] &&
                   (cmd.cur_b != cmd.cur_a);
      s1_idx_ff <= cmd.cur_b[AW-1:0];
      s2_v_ff   <= s1_v_ff;
      s2_idx_ff <= s1_idx_ff;
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= sq_in[k];
      end
      s3_v_ff   <= s2_v_ff;
      s3_idx_ff <= s2_idx_ff;
      s3_sum_ff <= DW'(sq_ff[0]) + DW'(sq_ff[1]) + DW'(sq_ff[2]);
      if (s3_act_ff && s3_v_ff && (!best_have_ff || s3_sum_ff < best_ff)) begin
         best_ff     <= s3_sum_ff;
         best_idx_ff <= s3_idx_ff;
      end
      if (cmd.emit_merge) begin
         node_id_ff      <= cmd.pos_wr_addr;
         child_first_ff  <= cmd.cur_a;
         child_second_ff <= cmd.cur_b;
         mid_x_ff        <= mid_sum[0][C:1];
         mid_y_ff        <= mid_sum[1][C:1];
         mid_z_ff        <= mid_sum[2][C:1];
         members_ff      <= mnnt_pkg::CNT_W'(merge_members);
         last_node_ff    <= (mnnt_pkg::CNT_W'(merge_members) == cmd.star_total);
         empty_ff        <= 1'b0;
         ovf_ff          <= cmd.overflow;
      end else if (cmd.emit_single) begin
         node_id_ff      <= '0;
         child_first_ff  <= '0;
         child_second_ff <= '0;
         mid_x_ff        <= pos_rd_data[0 +: C];
         mid_y_ff        <= pos_rd_data[C +: C];
         mid_z_ff        <= pos_rd_data[2*C +: C];
         members_ff      <= mnnt_pkg::CNT_W'(pos_rd_data[3*C +: MW]);
         last_node_ff    <= 1'b1;
         empty_ff        <= 1'b1;
         ovf_ff          <= cmd.overflow;
      end
   end

   assign status.free_a     = !attached_ff[cmd.cur_a[AW-1:0]];
   assign status.nb_rd_data = mnnt_pkg::IDX_W'(nb_rd_data);
   assign status.sweep_busy = s1_act_ff | s2_act_ff | s3_act_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.node_id      = node_id_ff;
   assign rsp_chan.child_first  = child_first_ff;
   assign rsp_chan.child_second = child_second_ff;
   assign rsp_chan.mid_x        = mid_x_ff;
   assign rsp_chan.mid_y        = mid_y_ff;
   assign rsp_chan.mid_z        = mid_z_ff;
   assign rsp_chan.member_count = members_ff;
   assign rsp_chan.last_node    = last_node_ff;
   assign rsp_chan.empty_tree   = empty_ff;
   assign rsp_chan.overflow     = ovf_ff;

endmodule

// ----- tb/sv/tb_mutual_nearest_neighbour_tree_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mutual_nearest_neighbour_tree_top
// self-checking bench for the tree builder: star sets are sent through the
// request channel, a local tree predictor builds the expected node records,
// and each record leaving the block is compared field by field
// ----------------------------------------------------------------------------
module tb_mutual_nearest_neighbour_tree_top;

   localparam int STAR_CAP   = mnnt_pkg::MAX_STARS_DEF;
   localparam int NODE_SLOTS = 2 * STAR_CAP - 1;
   localparam int NO_PARENT  = 127;
   localparam int WATCH_MAX  = 400000;
   localparam int CW         = mnnt_pkg::COORD_W;

   typedef struct {
      logic [mnnt_pkg::IDX_W-1:0]   node_id;
      logic [mnnt_pkg::IDX_W-1:0]   child_first;
      logic [mnnt_pkg::IDX_W-1:0]   child_second;
      logic [mnnt_pkg::COORD_W-1:0] mid_x;
      logic [mnnt_pkg::COORD_W-1:0] mid_y;
      logic [mnnt_pkg::COORD_W-1:0] mid_z;
      logic [mnnt_pkg::CNT_W-1:0]   member_count;
      logic                         last_node;
      logic                         empty_tree;
      logic                         overflow;
   } node_rec_type;

   logic clock;
   logic reset;
   mnnt_req_if req_chan ();
   mnnt_rsp_if rsp_chan ();

   mutual_nearest_neighbour_tree_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   longint       tree_pos [NODE_SLOTS][3];
   int           tree_parent [NODE_SLOTS];
   int           tree_near [NODE_SLOTS];
   int           tree_members [NODE_SLOTS];
   int           stars_held;
   int           nodes_made;
   bit           dropped_flag;
   node_rec_type node_records_q [$];

   int error_count = 0;
   int idle_cycles = 0;
   int send_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int random_items = 0;

   function automatic void clear_tree();
      for (int i = 0; i < NODE_SLOTS; i++) begin
         tree_parent[i] = NO_PARENT;
         tree_members[i] = 0;
         tree_near[i] = 0;
         for (int k = 0; k < 3; k++) tree_pos[i][k] = 0;
      end
      stars_held = 0;
      nodes_made = 0;
      dropped_flag = 0;
   endfunction

   function automatic void push_record(int id, int c1, int c2, int cnt, bit lst, bit emp);
      node_rec_type r;
      r.node_id = mnnt_pkg::IDX_W'(id);
      r.child_first = mnnt_pkg::IDX_W'(c1);
      r.child_second = mnnt_pkg::IDX_W'(c2);
      r.mid_x = tree_pos[id][0][CW-1:0];
      r.mid_y = tree_pos[id][1][CW-1:0];
      r.mid_z = tree_pos[id][2][CW-1:0];
      r.member_count = mnnt_pkg::CNT_W'(cnt);
      r.last_node = lst;
      r.empty_tree = emp;
      r.overflow = dropped_flag;
      node_records_q.push_back(r);
   endfunction

   function automatic longint unsigned span_sq(int a, int b);
      longint unsigned s;
      longint d;
      s = 0;
      for (int k = 0; k < 3; k++) begin
         d = tree_pos[a][k] - tree_pos[b][k];
         if (d < 0) d = -d;
         s += longint'(d) * longint'(d);
      end
      return s;
   endfunction

   function automatic void grow_tree();
      int             free_ids [NODE_SLOTS];
      int             nfree;
      int             a;
      int             b;
      int             p;
      bit             have;
      longint unsigned best;
      longint unsigned d;
      nodes_made = stars_held;
      if (stars_held == 1) begin
         push_record(0, 0, 0, 1, 1'b1, 1'b1);
         return;
      end
      for (int rnd = 0; rnd < STAR_CAP && nodes_made < NODE_SLOTS; rnd++) begin
         nfree = 0;
         for (int i = 0; i < nodes_made; i++)
            if (tree_parent[i] == NO_PARENT) begin
               free_ids[nfree] = i;
               nfree++;
            end
         if (nfree <= 1) break;
         for (int ii = 0; ii < nfree; ii++) begin
            a = free_ids[ii];
            have = 0;
            best = 0;
            for (int jj = 0; jj < nfree; jj++) begin
               b = free_ids[jj];
               if (a != b) begin
                  d = span_sq(a, b);
                  if (!have || d < best) begin
                     have = 1;
                     best = d;
                     tree_near[a] = b;
                  end
               end
            end
         end
         for (int ii = 0; ii + 1 < nfree; ii++) begin
            a = free_ids[ii];
            for (int jj = ii + 1; jj < nfree; jj++) begin
               b = free_ids[jj];
               if (tree_near[a] == b && tree_near[b] == a && nodes_made < NODE_SLOTS) begin
                  p = nodes_made;
                  tree_parent[a] = p;
                  tree_parent[b] = p;
                  for (int k = 0; k < 3; k++)
                     tree_pos[p][k] = (tree_pos[a][k] + tree_pos[b][k]) >>> 1;
                  tree_members[p] = tree_members[a] + tree_members[b];
                  nodes_made++;
                  push_record(p, a, b, tree_members[p], tree_members[p] == stars_held, 1'b0);
               end
            end
         end
      end
   endfunction

   function automatic void load_star(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                     logic signed [CW-1:0] z, logic lst);
      if (stars_held < STAR_CAP) begin
         tree_pos[stars_held][0] = longint'(x);
         tree_pos[stars_held][1] = longint'(y);
         tree_pos[stars_held][2] = longint'(z);
         tree_members[stars_held] = 1;
         tree_parent[stars_held] = NO_PARENT;
         stars_held++;
      end else begin
         dropped_flag = 1;
      end
      if (lst) begin
         grow_tree();
         clear_tree();
      end
   endfunction

   task automatic send_star(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic signed [CW-1:0] z, input logic lst);
      bit got;
      while (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.coord_x <= x;
      req_chan.coord_y <= y;
      req_chan.coord_z <= z;
      req_chan.last_star <= lst;
      do begin
         @(negedge clock);
         got = req_chan.ready;
         if (got) load_star(x, y, z, lst);
         @(posedge clock);
      end while (!got);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (node_records_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      return CW'($urandom());
   endfunction

   // random set; clustered sets give near ties and duplicate positions
   task automatic send_random_set(input int n);
      logic [CW-1:0] base [3];
      int            spread;
      bit            cluster;
      cluster = 1'($urandom_range(1));
      spread = int'($urandom_range(1, 8));
      for (int k = 0; k < 3; k++) base[k] = rand_coord();
      for (int i = 0; i < n; i++) begin
         if (cluster)
            send_star(base[0] + CW'($urandom_range(spread)),
                      base[1] + CW'($urandom_range(spread)),
                      base[2] + CW'($urandom_range(spread)), i == n - 1);
         else
            send_star(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
      end
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // result checking and acceptance tracking
   always @(negedge clock) begin
      node_rec_type w;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (node_records_q.size() == 0) begin
            $display("unexpected record node %0d at %0t", rsp_chan.node_id, $realtime);
            error_count++;
         end else begin
            w = node_records_q.pop_front();
            if (rsp_chan.node_id !== w.node_id)
               report_mismatch("node_id", longint'(rsp_chan.node_id), longint'(w.node_id));
            if (rsp_chan.child_first !== w.child_first)
               report_mismatch("child_first", longint'(rsp_chan.child_first),
                               longint'(w.child_first));
            if (rsp_chan.child_second !== w.child_second)
               report_mismatch("child_second", longint'(rsp_chan.child_second),
                               longint'(w.child_second));
            if (rsp_chan.mid_x !== w.mid_x)
               report_mismatch("mid_x", longint'(rsp_chan.mid_x), longint'(w.mid_x));
            if (rsp_chan.mid_y !== w.mid_y)
               report_mismatch("mid_y", longint'(rsp_chan.mid_y), longint'(w.mid_y));
            if (rsp_chan.mid_z !== w.mid_z)
               report_mismatch("mid_z", longint'(rsp_chan.mid_z), longint'(w.mid_z));
            if (rsp_chan.member_count !== w.member_count)
               report_mismatch("member_count", longint'(rsp_chan.member_count),
                               longint'(w.member_count));
            if (rsp_chan.last_node !== w.last_node)
               report_mismatch("last_node", longint'(rsp_chan.last_node),
                               longint'(w.last_node));
            if (rsp_chan.empty_tree !== w.empty_tree)
               report_mismatch("empty_tree", longint'(rsp_chan.empty_tree),
                               longint'(w.empty_tree));
            if (rsp_chan.overflow !== w.overflow)
               report_mismatch("overflow", longint'(rsp_chan.overflow),
                               longint'(w.overflow));
         end
      end
   end

   // receiver with random stalls and long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      while (idle_cycles < WATCH_MAX) @(negedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic test_single_star();
      send_star(24'sh7FFFFF, 24'sh800000, 24'sh000000, 1'b1);
      send_star(24'sh000000, 24'sh000000, 24'sh000000, 1'b1);
      drain();
   endtask

   task automatic test_extremes();
      send_star(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
      send_star(24'sh800000, 24'sh800000, 24'sh800000, 1'b1);
      send_star(24'sh800001, 24'sh000001, 24'sh7FFFFE, 1'b0);
      send_star(24'sh800000, 24'shFFFFFF, 24'sh7FFFFF, 1'b1);
      drain();
   endtask

   // equal distances and duplicate positions
   task automatic test_ties();
      send_star(24'sd0, 24'sd0, 24'sd0, 1'b0);
      send_star(24'sd1, 24'sd0, 24'sd0, 1'b0);
      send_star(24'sd2, 24'sd0, 24'sd0, 1'b0);
      send_star(24'sd3, 24'sd0, 24'sd0, 1'b1);
      send_star(24'sd5, 24'sd5, 24'sd5, 1'b0);
      send_star(24'sd5, 24'sd5, 24'sd5, 1'b0);
      send_star(24'sd5, 24'sd5, 24'sd5, 1'b1);
      send_star(-24'sd1, 24'sd0, 24'sd0, 1'b0);
      send_star(24'sd1, 24'sd0, 24'sd0, 1'b0);
      send_star(24'sd0, 24'sd1, 24'sd0, 1'b0);
      send_star(24'sd0, -24'sd1, 24'sd0, 1'b1);
      drain();
   endtask

   // full set plus dropped stars, with the receiver held off meanwhile
   task automatic test_capacity_pressure();
      hold_request = 6000;
      for (int i = 0; i < STAR_CAP + 2; i++)
         send_star(rand_coord(), rand_coord(), rand_coord(), i == STAR_CAP + 1);
      send_random_set(5);
      drain();
   endtask

   task automatic test_random(input int sp, input int rp, input int items);
      int n;
      int sent;
      int pick;
      send_pct = sp;
      stall_pct = rp;
      sent = 0;
      while (sent < items) begin
         pick = int'($urandom_range(99));
         if (pick < 5) n = 1;
         else if (pick < 85) n = int'($urandom_range(2, 6));
         else n = int'($urandom_range(7, 16));
         send_random_set(n);
         sent += n;
      end
      drain();
      send_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.coord_x = '0;
      req_chan.coord_y = '0;
      req_chan.coord_z = '0;
      req_chan.last_star = 1'b0;
      clear_tree();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_star();
      test_extremes();
      test_ties();
      test_capacity_pressure();
      test_random(0, 0, 12);
      test_random(69, 0, 12);
      test_random(0, 69, 12);
      test_random(13, 13, 12);
      repeat (200) @(posedge clock);
      if (error_count == 0 && node_records_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
